### rtl/rlbp_pkg.sv
// Shared types, codes and tables for the rank line base64 parser.
// No dependencies; imported by rlbp_step and rank_line_base64_parser.
package rlbp_pkg;

   // Field widths and limits
   localparam int RLBP_RANK_W          = 30;
   localparam int RLBP_SEXT_W          = 18;
   localparam int RLBP_RES_SLOTS       = 3;
   localparam int RLBP_MAX_RANK_DIGITS = 9;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5A;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_LC_Z  = 8'h7A;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_RANK  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Error codes
   typedef enum logic [2:0] {
      ERR_NO_SPACE    = 3'd0,
      ERR_EXTRA_SPACE = 3'd1,
      ERR_BAD_CHAR    = 3'd2,
      ERR_BAD_LENGTH  = 3'd3,
      ERR_BAD_RANK    = 3'd4,
      ERR_TOO_LONG    = 3'd5,
      ERR_PADDING     = 3'd6
   } err_type;

   // Line phase, one-hot
   typedef enum logic [2:0] {
      PHASE_PIECE   = 3'b001,
      PHASE_RANK    = 3'b010,
      PHASE_DISCARD = 3'b100
   } phase_type;

   // Per-line parser state (digit count lives apart, its width follows the parameter)
   typedef struct packed {
      phase_type              phase;
      logic [RLBP_SEXT_W-1:0] sext;
      logic [1:0]             qpos;
      logic [1:0]             pad;
      logic                   piece_ne;
      logic                   line_ne;
      logic [RLBP_RANK_W-1:0] rank;
   } st_type;

   localparam st_type ST_RESET = '{
      phase:    PHASE_PIECE,
      sext:     '0,
      qpos:     2'd0,
      pad:      2'd0,
      piece_ne: 1'b0,
      line_ne:  1'b0,
      rank:     '0
   };

   // One result
   typedef struct packed {
      kind_type               kind;
      logic [7:0]             byte_value;
      logic [RLBP_RANK_W-1:0] rank_value;
      err_type                error_code;
   } res_type;

   // Base64 alphabet lookup: {valid, sextet}
   function automatic logic [6:0] rlbp_sextet(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= CH_UC_A && c <= CH_UC_Z) begin
         r = {1'b1, 6'(c - CH_UC_A)};
      end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
         r = {1'b1, 6'(c - CH_LC_A + 8'd26)};
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         r = {1'b1, 6'(c - CH_ZERO + 8'd52)};
      end else if (c == CH_PLUS) begin
         r = {1'b1, 6'd62};
      end else if (c == CH_SLASH) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage

### rtl/rlbp_step.sv
// Next-state and result logic for one byte of the rank line parser.
// Purely combinational; depends on rlbp_pkg.
module rlbp_step #(
   parameter int MAX_RANK_DIGITS = rlbp_pkg::RLBP_MAX_RANK_DIGITS,
   parameter int DIG_W           = $clog2(MAX_RANK_DIGITS + 1)
) (
   input  logic [7:0]        in_byte,
   input  logic              end_of_file,
   input  rlbp_pkg::st_type  st,
   input  logic [DIG_W-1:0]  dig,
   output rlbp_pkg::st_type  st_nx,
   output logic [DIG_W-1:0]  dig_nx,
   output rlbp_pkg::res_type res [rlbp_pkg::RLBP_RES_SLOTS],
   output logic [1:0]        res_cnt
);
   import rlbp_pkg::*;

   logic [6:0]             sx;
   logic [5:0]             v;
   logic                   quiet;
   logic                   fail_now;
   err_type                fail_code;
   logic                   do_end;
   logic [1:0]             pad_n;
   logic [1:0]             keep;
   logic [5:0]             sa, sb, sc;
   logic [3:0]             digit;
   logic [RLBP_RANK_W-1:0] rank_x10;

   assign sx       = rlbp_sextet(in_byte);
   assign digit    = in_byte[3:0];
   assign rank_x10 = (st.rank << 3) + (st.rank << 1) + RLBP_RANK_W'(digit);
   assign sa       = st.sext[17:12];
   assign sb       = st.sext[11:6];
   assign sc       = st.sext[5:0];

   always_comb begin
      st_nx     = st;
      dig_nx    = dig;
      res_cnt   = 2'd0;
      fail_now  = 1'b0;
      fail_code = ERR_NO_SPACE;
      do_end    = 1'b0;
      quiet     = end_of_file && (in_byte != CH_SPACE);
      v         = sx[5:0];
      pad_n     = st.pad;
      keep      = 2'd3;
      for (int i = 0; i < RLBP_RES_SLOTS; i++) begin
         res[i] = '{kind: KIND_BYTE, byte_value: 8'd0, rank_value: '0,
                    error_code: ERR_NO_SPACE};
      end

      if (in_byte == CH_LF) begin
         do_end = 1'b1;
      end else if (in_byte != CH_NUL) begin
         st_nx.line_ne = 1'b1;
         // Base64 piece
         if (st.phase == PHASE_PIECE) begin
            if (in_byte == CH_SPACE) begin
               if (!st.piece_ne || st.qpos != 2'd0) begin
                  fail_now  = 1'b1;
                  fail_code = ERR_BAD_LENGTH;
               end else begin
                  st_nx.phase = PHASE_RANK;
               end
            end else if (!sx[6] && in_byte != CH_EQ) begin
               fail_now  = 1'b1;
               fail_code = ERR_BAD_CHAR;
            end else if (st.pad != 2'd0 && st.qpos == 2'd0) begin
               fail_now  = 1'b1;
               fail_code = ERR_PADDING;
            end else if (in_byte == CH_EQ && st.qpos < 2'd2) begin
               fail_now  = 1'b1;
               fail_code = ERR_PADDING;
            end else if (in_byte != CH_EQ && st.pad != 2'd0) begin
               fail_now  = 1'b1;
               fail_code = ERR_PADDING;
            end else begin
               if (in_byte == CH_EQ) begin
                  pad_n = st.pad + 2'd1;
                  v     = 6'd0;
               end
               st_nx.pad      = pad_n;
               st_nx.piece_ne = 1'b1;
               if (st.qpos != 2'd3) begin
                  st_nx.sext = {st.sext[RLBP_SEXT_W-7:0], v};
                  st_nx.qpos = st.qpos + 2'd1;
               end else begin
                  // Group complete: emit one to three bytes, none when the file ends on this byte
                  keep       = 2'd3 - (pad_n[1] ? 2'd2 : pad_n);
                  st_nx.sext = '0;
                  st_nx.qpos = 2'd0;
                  if (!quiet) begin
                     res[0].byte_value = {sa, sb[5:4]};
                     res[1].byte_value = {sb[3:0], sc[5:2]};
                     res[2].byte_value = {sc[1:0], v};
                     res_cnt           = keep;
                  end
               end
            end
         // Decimal rank
         end else if (st.phase == PHASE_RANK) begin
            if (in_byte == CH_SPACE) begin
               fail_now  = 1'b1;
               fail_code = ERR_EXTRA_SPACE;
            end else if (in_byte < CH_ZERO || in_byte > CH_NINE) begin
               fail_now  = 1'b1;
               fail_code = ERR_BAD_RANK;
            end else if (dig >= DIG_W'(MAX_RANK_DIGITS)) begin
               fail_now  = 1'b1;
               fail_code = ERR_TOO_LONG;
            end else begin
               st_nx.rank = rank_x10;
               dig_nx     = dig + DIG_W'(1);
            end
         end
         if (end_of_file) do_end = 1'b1;
      end else if (end_of_file) begin
         do_end = 1'b1;
      end

      // Error: single result, drop the rest of the line
      if (fail_now) begin
         res[0].kind       = KIND_ERROR;
         res[0].error_code = fail_code;
         res_cnt           = 2'd1;
         st_nx.phase       = PHASE_DISCARD;
      end

      // Line end; never coincides with emitted bytes, and adds no result after an error
      if (do_end) begin
         if (st_nx.line_ne) begin
            case (st_nx.phase)
               PHASE_PIECE: begin
                  res[0].kind       = KIND_ERROR;
                  res[0].error_code = ERR_NO_SPACE;
                  res_cnt           = 2'd1;
               end
               PHASE_RANK: begin
                  if (dig_nx == '0) begin
                     res[0].kind       = KIND_ERROR;
                     res[0].error_code = ERR_BAD_RANK;
                  end else begin
                     res[0].kind       = KIND_RANK;
                     res[0].rank_value = st_nx.rank;
                  end
                  res_cnt = 2'd1;
               end
               default: ;
            endcase
         end
         st_nx  = ST_RESET;
         dig_nx = '0;
      end
   end

endmodule

### rtl/rank_line_base64_parser.sv
// Rank line base64 parser: one file byte per request, 0 to 3 results each.
// Each byte waits in the request register, then its results go to the result buffer.
// Throughput: one byte per cycle while bytes give at most one result and rsp_ready
// is high; more results hold the buffer, one result per cycle while rsp_ready is high.
// Reset (synchronous, active high) returns the line state to the start of a line
// and empties the request and result registers. Depends on rlbp_pkg, rlbp_step.
module rank_line_base64_parser #(
   parameter int MAX_RANK_DIGITS = rlbp_pkg::RLBP_MAX_RANK_DIGITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_end_of_file,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_kind,
   output logic [7:0]                       rsp_byte_value,
   output logic [rlbp_pkg::RLBP_RANK_W-1:0] rsp_rank_value,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_last_of_run
);
   import rlbp_pkg::*;

   localparam int DIG_W = $clog2(MAX_RANK_DIGITS + 1);

   // Request register
   logic             hold_valid_ff;
   logic [7:0]       hold_byte_ff;
   logic             hold_eof_ff;

   // Line state
   st_type           st_ff, st_in;
   logic [DIG_W-1:0] dig_ff, dig_in;

   // Result buffer
   res_type          res_ff [RLBP_RES_SLOTS];
   res_type          res_in [RLBP_RES_SLOTS];
   logic [1:0]       rem_ff;
   logic [1:0]       rd_ff;
   logic [1:0]       cnt_in;

   logic             drain_done;
   logic             advance;

   rlbp_step #(
      .MAX_RANK_DIGITS (MAX_RANK_DIGITS),
      .DIG_W           (DIG_W)
   ) u_step (
      .in_byte     (hold_byte_ff),
      .end_of_file (hold_eof_ff),
      .st          (st_ff),
      .dig         (dig_ff),
      .st_nx       (st_in),
      .dig_nx      (dig_in),
      .res         (res_in),
      .res_cnt     (cnt_in)
   );

   // Held byte moves on once the buffer is empty or its last result leaves
   assign drain_done = (rem_ff == 2'd0) || (rem_ff == 2'd1 && rsp_ready);
   assign advance    = hold_valid_ff && drain_done;
   assign req_ready  = !hold_valid_ff || advance;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         hold_valid_ff <= 1'b1;
      end else if (advance) begin
         hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_byte_ff <= req_in_byte;
         hold_eof_ff  <= req_end_of_file;
      end
   end

   // Line state update
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_RESET;
         dig_ff <= '0;
      end else if (advance) begin
         st_ff  <= st_in;
         dig_ff <= dig_in;
      end
   end

   // Result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
         rd_ff  <= 2'd0;
      end else if (advance) begin
         rem_ff <= cnt_in;
         rd_ff  <= 2'd0;
      end else if (rsp_valid && rsp_ready) begin
         rem_ff <= rem_ff - 2'd1;
         rd_ff  <= rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   // Outputs
   assign rsp_valid       = (rem_ff != 2'd0);
   assign rsp_last_of_run = (rem_ff == 2'd1);
   assign rsp_kind        = res_ff[rd_ff].kind;
   assign rsp_byte_value  = res_ff[rd_ff].byte_value;
   assign rsp_rank_value  = res_ff[rd_ff].rank_value;
   assign rsp_error_code  = res_ff[rd_ff].error_code;

   // Checks
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rem_ff} + {1'b0, rd_ff}) <= 3'd3)
      else $error("result buffer read past its fill");

   a_single_nonbyte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_BYTE) |-> rsp_last_of_run)
      else $error("rank or error result not alone in its run");

   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && rem_ff > 2'd1) |-> !req_ready)
      else $error("request taken while request register is still busy");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_run && !hold_valid_ff) |=> !rsp_valid)
      else $error("results appeared without a pending byte");

endmodule
